FILE: hdl/lru_directory_block_cache_assert.svh
// Assertion macros used by the checker of the directory cache.
`ifndef LRU_DIRECTORY_BLOCK_CACHE_ASSERT_SVH
`define LRU_DIRECTORY_BLOCK_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LDBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("directory cache assertion failed");

// Implication checked a fixed number of cycles later.
`define LDBC_ASSERT_DELAY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("directory cache assertion failed");

`endif

FILE: hdl/ldbc_pkg.sv
// Package: sizes, request and response beat types of the directory cache.
package ldbc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int SLOT_W  = 3;

    localparam logic [31:0] PART_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] block_pos;
        logic [31:0] block_size;
        logic        fill_ok;
    } t_req;

    typedef struct packed {
        logic              available;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              size_mismatch;
        logic              evicted;
        logic [31:0]       evicted_pos;
        logic              out_of_range;
    } t_rsp;

endpackage

FILE: hdl/ldbc_enc.sv
// One-hot to binary encoder for slot vectors.
module ldbc_enc (
    input  logic [ldbc_pkg::ENTRIES-1:0] i_onehot,
    output logic [ldbc_pkg::IDX_W-1:0]   o_idx
);
    import ldbc_pkg::*;

    // At most one bit is set, so OR the indexes of set bits.
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_onehot[i]) begin
                o_idx = o_idx | IDX_W'(i);
            end
        end
    end

endmodule

FILE: hdl/ldbc_dir.sv
// Directory state: tags, sizes, valid bits, recency ranks and their update.
module ldbc_dir (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  ldbc_pkg::t_req  i_req,
    input  logic [31:0]     i_partition_bytes,
    output ldbc_pkg::t_rsp  o_rsp
);
    import ldbc_pkg::*;

    logic [31:0]      r_key [ENTRIES];
    logic [31:0]      r_size[ENTRIES];
    logic [AGE_W-1:0] r_age [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [AGE_W-1:0] n_age [ENTRIES];
    logic [ENTRIES-1:0] n_valid;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] valid_mid;
    logic [ENTRIES-1:0] free_oh;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic               hit;
    logic               evict;
    logic               insert;
    logic               oor_raw;
    logic               mismatch;
    logic [AGE_W-1:0]   old_age;
    logic [31:0]        victim_key;
    logic [32:0]        range_end;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == i_req.block_pos);
            victim[i] = r_valid[i] && (r_age[i] == AGE_W'(ENTRIES - 1));
        end
    end

    // Ranks of valid entries are distinct, so a full directory has exactly
    // one entry at the oldest rank.
    assign hit       = |match;
    assign evict     = i_vld && !hit && (&r_valid);
    assign valid_mid = evict ? (r_valid & ~victim) : r_valid;
    assign free_oh   = ~valid_mid & (valid_mid + ENTRIES'(1));

    assign range_end = {1'b0, i_req.block_pos} + {1'b0, i_req.block_size};
    assign oor_raw   = (i_req.block_pos >= i_partition_bytes) ||
                       (range_end > {1'b0, i_partition_bytes});
    assign insert    = i_vld && !hit && !oor_raw && i_req.fill_ok && (|free_oh);

    // Select the hit entry's rank and size, and the victim key, by AND-OR.
    always_comb begin
        old_age    = '0;
        mismatch   = 1'b0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                old_age  = old_age | r_age[i];
                mismatch = mismatch | (r_size[i] != i_req.block_size);
            end
            if (victim[i]) begin
                victim_key = victim_key | r_key[i];
            end
        end
    end

    ldbc_enc u_hit_enc (
        .i_onehot (match),
        .o_idx    (hit_idx)
    );

    ldbc_enc u_free_enc (
        .i_onehot (free_oh),
        .o_idx    (free_idx)
    );

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < ENTRIES; i++) begin
            n_age[i] = r_age[i];
            if (i_vld && hit) begin
                if (match[i]) begin
                    n_age[i] = '0;
                end else if (r_valid[i] && (r_age[i] < old_age)) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
            if (evict && victim[i]) begin
                n_valid[i] = 1'b0;
                n_age[i]   = '0;
            end
            if (insert) begin
                if (free_oh[i]) begin
                    n_valid[i] = 1'b1;
                    n_age[i]   = '0;
                end else if (valid_mid[i]) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (insert && free_oh[i]) begin
                r_key[i]  <= i_req.block_pos;
                r_size[i] <= i_req.block_size;
            end
        end
    end

    always_comb begin
        o_rsp               = '0;
        o_rsp.hit           = hit;
        o_rsp.available     = hit || insert;
        o_rsp.size_mismatch = hit && mismatch;
        o_rsp.evicted       = evict;
        o_rsp.evicted_pos   = evict ? victim_key : 32'd0;
        o_rsp.out_of_range  = !hit && oor_raw;
        if (hit) begin
            o_rsp.slot = SLOT_W'(hit_idx);
        end else if (insert) begin
            o_rsp.slot = SLOT_W'(free_idx);
        end
    end

endmodule

FILE: hdl/lru_directory_block_cache.sv
// Top level: request and result registers around the LRU directory.
//
// Fully associative LRU tag directory of ENTRIES directory blocks keyed by
// partition byte position. A request beat is taken at every rising edge
// where start is high; busy is always low, so one beat may enter in every
// cycle. Each request gives exactly one result beat, shown on o_rsp with
// o_done high for a single cycle once it has passed the request register
// and then the result register. The receiver cannot stall: capture o_rsp
// in the cycle o_done is high. The rate is one beat per cycle, set by the
// combinational lookup and recency update loop of the directory; results
// come back in request order. Write partition_bytes through i_cfg_we /
// i_cfg_data only while no request is in flight; it resets to all ones.
module lru_directory_block_cache (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ldbc_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data,
    output logic           o_done,
    output ldbc_pkg::t_rsp o_rsp
);
    import ldbc_pkg::*;

    logic        r_req_vld;
    t_req        r_req;
    logic [31:0] r_part;
    logic        r_done;
    t_rsp        r_rsp;
    t_rsp        dir_rsp;

    // The directory lookup is combinational and never stalls: never hold off.
    assign busy = 1'b0;

    // Hold the partition size; reset opens the whole address space.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= PART_RESET;
        end else if (i_cfg_we) begin
            r_part <= i_cfg_data;
        end
    end

    // Request register: advance one beat per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    ldbc_dir u_dir (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_vld             (r_req_vld),
        .i_req             (r_req),
        .i_partition_bytes (r_part),
        .o_rsp             (dir_rsp)
    );

    // Result register: one strobe per request, taken from the request valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_rsp <= dir_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

FILE: hdl/ldbc_checker.sv
// Port-level checker of the directory cache and its bind.
`include "lru_directory_block_cache_assert.svh"

module ldbc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input ldbc_pkg::t_rsp o_rsp
);

    `LDBC_ASSERT_DELAY(a_result_latency, start && !busy, o_done)
    `LDBC_ASSERT_IMPL(a_hit_available, o_done && o_rsp.hit, o_rsp.available)
    `LDBC_ASSERT_IMPL(a_oor_refused, o_done && o_rsp.out_of_range, !o_rsp.hit && !o_rsp.available)
    `LDBC_ASSERT_IMPL(a_mismatch_hit, o_done && o_rsp.size_mismatch, o_rsp.hit && !o_rsp.evicted)

endmodule

bind lru_directory_block_cache ldbc_checker u_ldbc_checker (.*);
